// ===== design/bpq_pkg.sv =====
// shared types and constants of the bounded min-first priority queue
`default_nettype none

package bpq_pkg;

    localparam int VALUE_BITS = 32;
    localparam int FIELD_PRIO_BITS = 16;
    localparam int FILL_BITS = 7;
    localparam int CAP_BITS = 7;
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic
    {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed
    {
        cmd_t                               command;
        logic signed [VALUE_BITS-1:0]       in_value;
        logic signed [FIELD_PRIO_BITS-1:0]  in_priority;
    } request_t;

    typedef struct packed
    {
        status_t                            status;
        logic signed [VALUE_BITS-1:0]       out_value;
        logic signed [FIELD_PRIO_BITS-1:0]  out_priority;
        logic [FILL_BITS-1:0]               fill_level;
    } result_t;

    // operation broadcast to every cell of the row
    typedef struct packed
    {
        logic insert;
        logic extract;
    } cell_op_t;

endpackage

`default_nettype wire

// ===== design/bounded_min_priority_queue_core.sv =====
// top level of the bounded min-first priority queue
`default_nettype none

// Bounded min-first priority queue held in a row of DEPTH cells kept sorted
// by priority, then by arrival. A request (insert or extract) is taken when
// start is high and busy is low; busy then stays high while the whole row
// moves at once, and no new request is taken until it drops. The result
// appears on result, marked by done for exactly one cycle, in the cycle after
// busy; it cannot be held off, so the receiver must take it then. Inserts
// into a full queue (fill at or above capacity, or at DEPTH) report overflow
// and change nothing; extracts from an empty queue report underflow. Among
// equal priorities the earliest insert leaves first. capacity is written over
// the cfg channel, which is always ready, and should only be written while no
// request is in flight.
module bounded_min_priority_queue_core #(
    parameter int DEPTH = 64,
    parameter int PRIORITY_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  bpq_pkg::request_t                    request,
    output logic                                 done,
    output bpq_pkg::result_t                     result,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [bpq_pkg::CAP_BITS-1:0]          cfg_data
);
    import bpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // request held for the cycle the row moves
    logic                       pending_reg;
    logic                       pending_next;
    request_t                   req_reg;
    logic [CAP_BITS-1:0]        capacity_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       done_reg;
    result_t                    result_reg;
    result_t                    result_next;

    logic                       accept;
    logic                       full;
    logic                       insert_ok;
    logic                       extract_ok;
    cell_op_t                   op;
    logic [31:0]                prio_wide;
    logic signed [PRIORITY_BITS-1:0] new_prio;
    logic [31:0]                out_prio_wide;
    logic [31:0]                fill_wide;

    // cell row wiring
    logic                               cell_valid [DEPTH];
    logic                               cell_gt    [DEPTH];
    logic signed [VALUE_BITS-1:0]       cell_value [DEPTH];
    logic signed [PRIORITY_BITS-1:0]    cell_prio  [DEPTH];

    assign accept    = start && !busy;
    assign busy      = pending_reg;
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // priority field read as a PRIORITY_BITS two's complement number
    assign prio_wide = {16'b0, req_reg.in_priority};
    assign new_prio  = prio_wide[PRIORITY_BITS-1:0];

    // fill never exceeds DEPTH, so held >= min(capacity, DEPTH) reduces to this
    assign full = (32'(count_reg) >= 32'(capacity_reg)) || (32'(count_reg) == 32'(DEPTH));

    assign insert_ok  = (req_reg.command == CMD_INSERT) && !full;
    assign extract_ok = (req_reg.command == CMD_EXTRACT) && (count_reg != '0);

    assign op.insert  = pending_reg && insert_ok;
    assign op.extract = pending_reg && extract_ok;

    assign pending_next = accept ? 1'b1 : 1'b0;

    always_comb
    begin
        count_next = count_reg;
        if (op.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.extract)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // head cell priority, masked to its width and fitted to the field
    always_comb
    begin
        out_prio_wide = '0;
        out_prio_wide[PRIORITY_BITS-1:0] = cell_prio[0];
    end

    assign fill_wide = 32'(count_next);

    always_comb
    begin
        result_next.status       = STATUS_DONE;
        result_next.out_value    = '0;
        result_next.out_priority = '0;
        result_next.fill_level   = fill_wide[FILL_BITS-1:0];
        case (req_reg.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    result_next.status = STATUS_OVERFLOW;
                end
            end
            CMD_EXTRACT:
            begin
                if (extract_ok)
                begin
                    result_next.out_value    = cell_value[0];
                    result_next.out_priority = out_prio_wide[FIELD_PRIO_BITS-1:0];
                end
                else
                begin
                    result_next.status = STATUS_UNDERFLOW;
                end
            end
            default:
            begin
                result_next.status = STATUS_DONE;
            end
        endcase
    end

    // the row: cell 0 is the head, each cell sees both neighbours
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                            l_valid;
        logic                            l_gt;
        logic signed [VALUE_BITS-1:0]    l_value;
        logic signed [PRIORITY_BITS-1:0] l_prio;
        logic                            r_valid;
        logic signed [VALUE_BITS-1:0]    r_value;
        logic signed [PRIORITY_BITS-1:0] r_prio;

        if (i == 0)
        begin : g_head
            // virtual left neighbour: valid and never greater
            assign l_valid = 1'b1;
            assign l_gt    = 1'b0;
            assign l_value = '0;
            assign l_prio  = '0;
        end
        else
        begin : g_body
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
            assign l_value = cell_value[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            // empty slot shifts in at the tail on extract
            assign r_valid = 1'b0;
            assign r_value = '0;
            assign r_prio  = '0;
        end
        else
        begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        bpq_cell #(
            .PB (PRIORITY_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .new_value   (req_reg.in_value),
            .new_prio    (new_prio),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .left_prio   (l_prio),
            .right_valid (r_valid),
            .right_value (r_value),
            .right_prio  (r_prio),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            done_reg     <= 1'b0;
            count_reg    <= '0;
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            pending_reg <= pending_next;
            done_reg    <= pending_reg;
            count_reg   <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (pending_reg)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("held count above depth");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == cell_valid[0])
        else $error("head cell validity disagrees with held count");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("request in flight produced no result");

    a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.fill_level) == 32'(count_reg)))
        else $error("reported fill level differs from held count");
`endif

endmodule

`default_nettype wire

// ===== design/bpq_cell.sv =====
// one slot of the sorted cell row
`default_nettype none

module bpq_cell #(
    parameter int PB = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  bpq_pkg::cell_op_t                      op,
    input  wire signed [bpq_pkg::VALUE_BITS-1:0]   new_value,
    input  wire signed [PB-1:0]                    new_prio,
    input  wire                                    left_valid,
    input  wire                                    left_gt,
    input  wire signed [bpq_pkg::VALUE_BITS-1:0]   left_value,
    input  wire signed [PB-1:0]                    left_prio,
    input  wire                                    right_valid,
    input  wire signed [bpq_pkg::VALUE_BITS-1:0]   right_value,
    input  wire signed [PB-1:0]                    right_prio,
    output logic                                   valid,
    output logic                                   gt,
    output logic signed [bpq_pkg::VALUE_BITS-1:0]  value,
    output logic signed [PB-1:0]                   prio
);
    import bpq_pkg::*;

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [VALUE_BITS-1:0]   value_reg;
    logic signed [VALUE_BITS-1:0]   value_next;
    logic signed [PB-1:0]           prio_reg;
    logic signed [PB-1:0]           prio_next;

    // strictly greater keeps equal priorities in arrival order
    assign gt    = valid_reg && (prio_reg > new_prio);
    assign valid = valid_reg;
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (op.extract)
        begin
            valid_next = right_valid;
            value_next = right_value;
            prio_next  = right_prio;
        end
        else if (op.insert)
        begin
            if (left_gt)
            begin
                valid_next = left_valid;
                value_next = left_value;
                prio_next  = left_prio;
            end
            else if (left_valid && (!valid_reg || gt))
            begin
                valid_next = 1'b1;
                value_next = new_value;
                prio_next  = new_prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

`default_nettype wire

// ===== sim/bounded_min_priority_queue_core_tb.sv =====
// self-checking testbench of the bounded min-first priority queue core
`default_nettype none

module bounded_min_priority_queue_core_tb;

    import bpq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int PRIO_WIDTH = 16;
    localparam int REPORT_LIMIT = 10;

    // one held entry of the mirrored queue
    typedef struct
    {
        logic signed [VALUE_BITS-1:0]  value;
        logic signed [PRIO_WIDTH-1:0]  prio;
    } held_entry_t;

    // mirror of the queue: predicts one result per accepted request and
    // checks the results in order of arrival
    class queue_mirror;
        held_entry_t   slots [QUEUE_DEPTH];
        int unsigned   held;
        int unsigned   capacity;
        result_t       awaited_results [$];
        int unsigned   faults;

        function new();
            held = 0;
            capacity = CAPACITY_RESET;
            faults = 0;
        endfunction

        function void set_capacity(logic [CAP_BITS-1:0] cap);
            capacity = cap;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // works out the result of one accepted request and moves the mirror on
        function void note_request(request_t req);
            result_t      res;
            int unsigned  limit;
            int unsigned  pos;
            res = '0;
            res.status = STATUS_DONE;
            limit = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity;
            if (req.command == CMD_INSERT)
            begin
                if (held >= limit)
                    res.status = STATUS_OVERFLOW;
                else
                begin
                    // stable: the newcomer goes behind every equal priority
                    pos = held;
                    while (pos > 0 && slots[pos-1].prio > req.in_priority)
                    begin
                        slots[pos] = slots[pos-1];
                        pos--;
                    end
                    slots[pos].value = req.in_value;
                    slots[pos].prio = req.in_priority;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                    res.status = STATUS_UNDERFLOW;
                else
                begin
                    res.out_value = slots[0].value;
                    res.out_priority = slots[0].prio;
                    for (int i = 1; i < held; i++)
                        slots[i-1] = slots[i];
                    held--;
                end
            end
            res.fill_level = held[FILL_BITS-1:0];
            awaited_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t exp_res;
            if (awaited_results.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("%0t: result with nothing awaited: status %0d value %0d prio %0d fill %0d",
                             $time, got.status, got.out_value, got.out_priority,
                             got.fill_level);
                return;
            end
            exp_res = awaited_results.pop_front();
            if (got.status !== exp_res.status || got.out_value !== exp_res.out_value ||
                got.out_priority !== exp_res.out_priority ||
                got.fill_level !== exp_res.fill_level)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("%0t: mismatch: status %0d/%0d value %0d/%0d prio %0d/%0d fill %0d/%0d (exp/got)",
                             $time, exp_res.status, got.status, exp_res.out_value,
                             got.out_value, exp_res.out_priority, got.out_priority,
                             exp_res.fill_level, got.fill_level);
            end
        endfunction
    endclass

    // clock and block ports
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    request_t             request;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_BITS-1:0]  cfg_data;

    queue_mirror mirror;

    bounded_min_priority_queue_core #(
        .DEPTH          (QUEUE_DEPTH),
        .PRIORITY_BITS  (PRIO_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // the strobe cannot be held off, so every marked cycle is checked
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_result(result);
    end

    // all tasks below are entered just after a falling edge and return on one

    // drive one request and hold it until the block takes it
    task automatic send_request(input request_t req);
        start <= 1'b1;
        request <= req;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
            @(negedge clk);
        end
        mirror.note_request(req);
        @(negedge clk);
    endtask

    // sender gap, with start held low for the given cycle count
    task automatic pause(input int unsigned cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // stop sending and wait for every awaited result
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge clk);
        while (mirror.pending() != 0)
            @(negedge clk);
    endtask

    // capacity write, only ever issued with the queue idle
    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
            @(negedge clk);
        end
        mirror.set_capacity(cap);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic request_t insert_req(input logic [VALUE_BITS-1:0] value,
                                            input logic [PRIO_WIDTH-1:0] prio);
        request_t req;
        req.command = CMD_INSERT;
        req.in_value = value;
        req.in_priority = prio;
        return req;
    endfunction

    // extract with junk in the ignored fields
    function automatic request_t extract_req();
        request_t req;
        req.command = CMD_EXTRACT;
        req.in_value = VALUE_BITS'($urandom);
        req.in_priority = PRIO_WIDTH'($urandom);
        return req;
    endfunction

    function automatic request_t random_request(input int unsigned insert_pct);
        int                          spread;
        logic [PRIO_WIDTH-1:0]       prio;
        if ($urandom_range(99) >= insert_pct)
            return extract_req();
        // narrow priority ranges give plenty of ties
        case ($urandom_range(3))
            0: prio = PRIO_WIDTH'($urandom);
            1:
            begin
                spread = int'($urandom_range(6)) - 3;
                prio = PRIO_WIDTH'(spread);
            end
            2:
            begin
                case ($urandom_range(3))
                    0: prio = 16'h8000;
                    1: prio = 16'h7fff;
                    2: prio = 16'h0000;
                    default: prio = 16'hffff;
                endcase
            end
            default: prio = PRIO_WIDTH'($urandom_range(15));
        endcase
        return insert_req(VALUE_BITS'($urandom), prio);
    endfunction

    // random traffic in bursts with random gaps, now and then a long gapless run
    task automatic run_traffic(input int unsigned count, input int unsigned insert_pct);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(9) == 0) ? 30 : $urandom_range(1, 12);
            for (int unsigned b = 0; b < burst && sent < count; b++)
            begin
                send_request(random_request(insert_pct));
                sent++;
            end
            if ($urandom_range(29) == 0)
                hold_until_drained();
            else if ($urandom_range(7) != 0)
                pause($urandom_range(1, 6));
        end
    endtask

    // stimulus
    initial
    begin
        mirror = new();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_capacity(7'd64);

        // empty queue, field extremes, then a tie that must leave in order
        send_request(extract_req());
        send_request(insert_req(32'h7fffffff, 16'h7fff));
        send_request(insert_req(32'h80000000, 16'h8000));
        pause(2);
        send_request(insert_req(32'h00000000, 16'h0000));
        send_request(insert_req(32'hffffffff, 16'hffff));
        send_request(insert_req(32'h00000001, 16'h0005));
        send_request(insert_req(32'h00000002, 16'h0005));
        repeat (7) send_request(extract_req());

        // capacity of one, then zero
        hold_until_drained();
        write_capacity(7'd1);
        send_request(insert_req(32'h12345678, 16'h0010));
        send_request(insert_req(32'h0badf00d, 16'h0001));
        hold_until_drained();
        write_capacity(7'd0);
        send_request(insert_req(32'h5a5a5a5a, 16'h0002));
        send_request(extract_req());
        send_request(extract_req());

        // capacity lowered below the fill: held entries stay, inserts refused until the fill drops below it
        hold_until_drained();
        write_capacity(7'd64);
        for (int i = 0; i < 4; i++)
            send_request(insert_req(VALUE_BITS'($urandom), PRIO_WIDTH'($urandom_range(3))));
        hold_until_drained();
        write_capacity(7'd2);
        send_request(insert_req(32'h00000077, 16'h0000));
        send_request(extract_req());
        send_request(extract_req());
        send_request(insert_req(32'h00000088, 16'h0001));
        send_request(extract_req());
        send_request(insert_req(32'h00000099, 16'h0002));
        send_request(extract_req());

        // random phases; capacity above the row saturates, so fill it right up
        hold_until_drained();
        write_capacity(7'd127);
        run_traffic(90, 85);
        hold_until_drained();
        write_capacity(7'd10);
        run_traffic(40, 50);
        hold_until_drained();
        write_capacity(7'd64);
        run_traffic(80, 30);
        hold_until_drained();
        write_capacity(7'd1);
        run_traffic(40, 50);
        hold_until_drained();
        write_capacity(7'd0);
        run_traffic(25, 50);
        hold_until_drained();
        write_capacity(CAP_BITS'($urandom_range(2, 63)));
        run_traffic(90, 60);
        hold_until_drained();
        write_capacity(7'd64);
        run_traffic(45, 55);
        hold_until_drained();
        run_traffic(45, 55);
        hold_until_drained();
        write_capacity(CAP_BITS'($urandom_range(0, 127)));
        run_traffic(90, 50);

        // let the last results settle, then report
        hold_until_drained();
        repeat (4) @(posedge clk);
        if (mirror.pending() != 0)
            mirror.faults += mirror.pending();
        if (mirror.faults == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
